// File: hdl/wbgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgs_pkg
// Shared widths, codes and inter-stage beat types of the wrapped bilinear
// grid sampler.
// ----------------------------------------------------------------------------
package wbgs_pkg;

  localparam int GRID_WIDTH_DEF  = 360;
  localparam int GRID_HEIGHT_DEF = 180;

  localparam int FRAC_W    = 8;
  localparam int COORD_X_W = 19;
  localparam int COORD_Y_W = 18;
  localparam int INDEX_W   = 16;
  localparam int VALUE_W   = 8;
  localparam int XI_RAW_W  = COORD_X_W - FRAC_W;
  localparam int YI_RAW_W  = COORD_Y_W - FRAC_W;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_t;

  typedef logic [FRAC_W-1:0]  frac_t;
  typedef logic [VALUE_W-1:0] byte_t;

  // One beat moving from the coordinate stages into the grid stages.
  typedef struct packed {
    logic  valid;
    logic  sample;
    frac_t fx;
    frac_t fy;
  } beat_t;

  // One sample beat moving from the grid stages into the blend stages.
  typedef struct packed {
    logic  valid;
    logic  last;
    frac_t fx;
    frac_t fy;
    byte_t here;
    byte_t right;
    byte_t below;
    byte_t diag;
  } fetch_t;

endpackage

// File: hdl/wrapped_bilinear_grid_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapped_bilinear_grid_sampler
// Byte grid with parity-banked storage and a six-stage bilinear sample path.
//
//   channel   handshake              fields
//   request   start, busy            req_type, write_index, write_value,
//                                    coord_x, coord_y
//   result    sample_valid (strobe)  sample_value
//
// A beat enters on every cycle with start high and busy low. A sample
// result strobes once its beat has passed stages A to F; a write gives none.
// Throughput is one beat per cycle while busy is low, set by the four parity
// banks that deliver a 2x2 neighborhood per read. After reset busy stays high
// while the clearing pass zeroes all ceil(W/2)*ceil(H/2) rows of each bank
// (16200 at 360 x 180), then never rises again. Results cannot be held off.
// ----------------------------------------------------------------------------
module wrapped_bilinear_grid_sampler #(
  parameter int GRID_WIDTH  = wbgs_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = wbgs_pkg::GRID_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  req_type,
  input  logic [wbgs_pkg::INDEX_W-1:0]          write_index,
  input  logic [wbgs_pkg::VALUE_W-1:0]          write_value,
  input  logic signed [wbgs_pkg::COORD_X_W-1:0] coord_x,
  input  logic signed [wbgs_pkg::COORD_Y_W-1:0] coord_y,
  output logic                                  sample_valid,
  output logic [wbgs_pkg::VALUE_W-1:0]          sample_value
);
  import wbgs_pkg::*;

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int YW = $clog2(GRID_HEIGHT);

  logic          in_valid;
  beat_t         beat;
  logic [XW-1:0] xi;
  logic [YW-1:0] yi;
  byte_t         wdata;
  fetch_t        fetch;

  assign in_valid = start && !busy;

  wbgs_wrap #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_wrap (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .req_type    (req_type),
    .write_index (write_index),
    .write_value (write_value),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .beat        (beat),
    .xi          (xi),
    .yi          (yi),
    .wdata       (wdata)
  );

  wbgs_grid #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_grid (
    .clk   (clk),
    .rst   (rst),
    .beat  (beat),
    .xi    (xi),
    .yi    (yi),
    .wdata (wdata),
    .busy  (busy),
    .fetch (fetch)
  );

  wbgs_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .fetch        (fetch),
    .sample_valid (sample_valid),
    .sample_value (sample_value)
  );

  a_busy_only_after_reset: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy)
    else $error("busy rose outside the clearing pass");

  a_no_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !sample_valid)
    else $error("result strobe during clearing pass");

endmodule

// File: hdl/wbgs_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgs_wrap
// Two stages: reciprocal multiply, then remainder correction. Turns sample
// coordinates into wrapped cell x/y and write indexes into cell x/y.
// ----------------------------------------------------------------------------
module wbgs_wrap #(
  parameter int GRID_WIDTH  = wbgs_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = wbgs_pkg::GRID_HEIGHT_DEF,
  localparam int XW = $clog2(GRID_WIDTH),
  localparam int YW = $clog2(GRID_HEIGHT)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   req_type,
  input  logic [wbgs_pkg::INDEX_W-1:0]           write_index,
  input  logic [wbgs_pkg::VALUE_W-1:0]           write_value,
  input  logic signed [wbgs_pkg::COORD_X_W-1:0]  coord_x,
  input  logic signed [wbgs_pkg::COORD_Y_W-1:0]  coord_y,
  output wbgs_pkg::beat_t                        beat,
  output logic [XW-1:0]                          xi,
  output logic [YW-1:0]                          yi,
  output wbgs_pkg::byte_t                        wdata
);
  import wbgs_pkg::*;

  localparam int SX = 2 * XI_RAW_W;
  localparam int SY = 2 * YI_RAW_W;
  localparam int SI = INDEX_W + 10;
  localparam longint unsigned MX = ((64'd1 << SX) + GRID_WIDTH - 1) / GRID_WIDTH;
  localparam longint unsigned MY = ((64'd1 << SY) + GRID_HEIGHT - 1) / GRID_HEIGHT;
  localparam longint unsigned MI = ((64'd1 << SI) + GRID_WIDTH - 1) / GRID_WIDTH;
  localparam int OFFX  = (1 << (XI_RAW_W - 1)) % GRID_WIDTH;
  localparam int OFFY  = (1 << (YI_RAW_W - 1)) % GRID_HEIGHT;
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int RX = XI_RAW_W + 2;
  localparam int RY = YI_RAW_W + 2;
  localparam int RI = INDEX_W + 2;

  // stage A: offset integer parts, multiply by reciprocals
  logic [XI_RAW_W-1:0]    ux;
  logic [YI_RAW_W-1:0]    uy;
  logic [XI_RAW_W+SX-1:0] px;
  logic [YI_RAW_W+SY-1:0] py;
  logic [INDEX_W+SI-1:0]  pi;

  assign ux = {~coord_x[COORD_X_W-1], coord_x[COORD_X_W-2:FRAC_W]};
  assign uy = {~coord_y[COORD_Y_W-1], coord_y[COORD_Y_W-2:FRAC_W]};
  assign px = (XI_RAW_W+SX)'(ux) * (XI_RAW_W+SX)'(MX);
  assign py = (YI_RAW_W+SY)'(uy) * (YI_RAW_W+SY)'(MY);
  assign pi = (INDEX_W+SI)'(write_index) * (INDEX_W+SI)'(MI);

  beat_t               a_beat;
  logic [XI_RAW_W-1:0] a_ux;
  logic [YI_RAW_W-1:0] a_uy;
  logic [XI_RAW_W-1:0] a_qx;
  logic [YI_RAW_W-1:0] a_qy;
  logic [INDEX_W-1:0]  a_idx;
  logic [INDEX_W-1:0]  a_qi;
  byte_t               a_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_beat.valid <= 1'b0;
    end else begin
      a_beat.valid <= in_valid &&
                      (req_type == REQ_SAMPLE || 32'(write_index) < CELLS);
    end
    a_beat.sample <= (req_type == REQ_SAMPLE);
    a_beat.fx     <= coord_x[FRAC_W-1:0];
    a_beat.fy     <= coord_y[FRAC_W-1:0];
    a_ux          <= ux;
    a_uy          <= uy;
    a_qx          <= px[XI_RAW_W+SX-1:SX];
    a_qy          <= py[YI_RAW_W+SY-1:SY];
    a_idx         <= write_index;
    a_qi          <= pi[INDEX_W+SI-1:SI];
    a_wdata       <= write_value;
  end

  // stage B: remainders with correction, remove the offset
  logic [RX-1:0]      rx0, rx1, rx2, rx3;
  logic [RY-1:0]      ry0, ry1, ry2, ry3;
  logic [RI-1:0]      ri0, ix;
  logic [INDEX_W-1:0] iy;
  logic               ri_neg;

  always_comb begin
    rx0 = RX'(a_ux) - RX'(a_qx) * RX'(GRID_WIDTH);
    rx1 = rx0[RX-1] ? rx0 + RX'(GRID_WIDTH) : rx0;
    rx2 = rx1 - RX'(OFFX);
    rx3 = rx2[RX-1] ? rx2 + RX'(GRID_WIDTH) : rx2;
    ry0 = RY'(a_uy) - RY'(a_qy) * RY'(GRID_HEIGHT);
    ry1 = ry0[RY-1] ? ry0 + RY'(GRID_HEIGHT) : ry0;
    ry2 = ry1 - RY'(OFFY);
    ry3 = ry2[RY-1] ? ry2 + RY'(GRID_HEIGHT) : ry2;
    ri0    = RI'(a_idx) - RI'(a_qi) * RI'(GRID_WIDTH);
    ri_neg = ri0[RI-1];
    ix     = ri_neg ? ri0 + RI'(GRID_WIDTH) : ri0;
    iy     = a_qi - INDEX_W'(ri_neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else begin
      beat.valid <= a_beat.valid;
    end
    beat.sample <= a_beat.sample;
    beat.fx     <= a_beat.fx;
    beat.fy     <= a_beat.fy;
    xi          <= a_beat.sample ? rx3[XW-1:0] : ix[XW-1:0];
    yi          <= a_beat.sample ? ry3[YW-1:0] : iy[YW-1:0];
    wdata       <= a_wdata;
  end

  a_cell_in_grid: assert property (@(posedge clk) disable iff (rst)
    beat.valid |-> (32'(xi) < GRID_WIDTH && 32'(yi) < GRID_HEIGHT))
    else $error("cell coordinate outside the grid");

endmodule

// File: hdl/wbgs_grid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgs_grid
// Grid store split in four banks by x and y parity, so a 2x2 neighborhood
// reads with one access per bank. Stage C forms bank addresses, stage D
// reads or writes. A clearing pass zeroes every bank row after reset.
// ----------------------------------------------------------------------------
module wbgs_grid #(
  parameter int GRID_WIDTH  = wbgs_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = wbgs_pkg::GRID_HEIGHT_DEF,
  localparam int XW = $clog2(GRID_WIDTH),
  localparam int YW = $clog2(GRID_HEIGHT)
) (
  input  logic             clk,
  input  logic             rst,
  input  wbgs_pkg::beat_t  beat,
  input  logic [XW-1:0]    xi,
  input  logic [YW-1:0]    yi,
  input  wbgs_pkg::byte_t  wdata,
  output logic             busy,
  output wbgs_pkg::fetch_t fetch
);
  import wbgs_pkg::*;

  localparam int WH         = (GRID_WIDTH + 1) / 2;
  localparam int HH         = (GRID_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = WH * HH;
  localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // stage C: neighbor coordinates and bank addresses
  logic          x_last, y_last;
  logic [XW-1:0] x1, col0, col1;
  logic [YW-1:0] y1, row0, row1;
  logic [BAW-1:0] off0, off1;

  always_comb begin
    x_last = (xi == XW'(GRID_WIDTH - 1));
    y_last = (yi == YW'(GRID_HEIGHT - 1));
    x1     = x_last ? '0 : xi + XW'(1);
    y1     = y_last ? '0 : yi + YW'(1);
    col0   = xi[0] ? x1 : xi;
    col1   = xi[0] ? xi : x1;
    row0   = yi[0] ? y1 : yi;
    row1   = yi[0] ? yi : y1;
    off0   = BAW'(row0 >> 1) * BAW'(WH);
    off1   = BAW'(row1 >> 1) * BAW'(WH);
  end

  beat_t          c_beat;
  logic           c_last;
  logic           c_sx, c_sy;
  byte_t          c_wdata;
  logic [BAW-1:0] c_addr [2][2];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_beat.valid <= 1'b0;
    end else begin
      c_beat.valid <= beat.valid;
    end
    c_beat.sample <= beat.sample;
    c_beat.fx     <= beat.fx;
    c_beat.fy     <= beat.fy;
    c_last        <= x_last || y_last;
    c_sx          <= xi[0];
    c_sy          <= yi[0];
    c_wdata       <= wdata;
    c_addr[0][0]  <= off0 + BAW'(col0 >> 1);
    c_addr[0][1]  <= off1 + BAW'(col0 >> 1);
    c_addr[1][0]  <= off0 + BAW'(col1 >> 1);
    c_addr[1][1]  <= off1 + BAW'(col1 >> 1);
  end

  // clearing pass
  logic           clearing;
  logic [BAW-1:0] clr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr      <= '0;
    end else if (clearing) begin
      clr <= clr + BAW'(1);
      if (clr == BAW'(BANK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign busy = clearing;

  // stage D: banks
  byte_t rd [2][2];

  for (genvar gx = 0; gx < 2; gx++) begin : g_col
    for (genvar gy = 0; gy < 2; gy++) begin : g_row
      byte_t          mem [BANK_DEPTH];
      logic           we;
      logic [BAW-1:0] wa;
      byte_t          wd;

      assign we = clearing || (c_beat.valid && !c_beat.sample &&
                               c_sx == 1'(gx) && c_sy == 1'(gy));
      assign wa = clearing ? clr : c_addr[gx][gy];
      assign wd = clearing ? '0 : c_wdata;

      always_ff @(posedge clk) begin
        if (we) begin
          mem[wa] <= wd;
        end
        rd[gx][gy] <= mem[c_addr[gx][gy]];
      end
    end
  end

  logic  d_valid, d_last, d_sx, d_sy;
  frac_t d_fx, d_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_beat.valid && c_beat.sample;
    end
    d_last <= c_last;
    d_sx   <= c_sx;
    d_sy   <= c_sy;
    d_fx   <= c_beat.fx;
    d_fy   <= c_beat.fy;
  end

  always_comb begin
    fetch.valid = d_valid;
    fetch.last  = d_last;
    fetch.fx    = d_fx;
    fetch.fy    = d_fy;
    fetch.here  = d_sx ? (d_sy ? rd[1][1] : rd[1][0]) : (d_sy ? rd[0][1] : rd[0][0]);
    fetch.right = d_sx ? (d_sy ? rd[0][1] : rd[0][0]) : (d_sy ? rd[1][1] : rd[1][0]);
    fetch.below = d_sx ? (d_sy ? rd[1][0] : rd[1][1]) : (d_sy ? rd[0][0] : rd[0][1]);
    fetch.diag  = d_sx ? (d_sy ? rd[0][0] : rd[0][1]) : (d_sy ? rd[1][0] : rd[1][1]);
  end

  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !c_beat.valid)
    else $error("beat in flight during clearing pass");

endmodule

// File: hdl/wbgs_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgs_blend
// Stage E blends horizontally (top and bottom rows), stage F blends
// vertically and drives the result strobe.
// ----------------------------------------------------------------------------
module wbgs_blend (
  input  logic             clk,
  input  logic             rst,
  input  wbgs_pkg::fetch_t fetch,
  output logic             sample_valid,
  output wbgs_pkg::byte_t  sample_value
);
  import wbgs_pkg::*;

  function automatic byte_t blend(input byte_t a, input byte_t b, input frac_t f);
    logic [16:0] s;
    s = 17'(a) * (17'd256 - 17'(f)) + 17'(b) * 17'(f);
    return s[15:8];
  endfunction

  logic  e_valid;
  byte_t e_top, e_bot;
  frac_t e_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= fetch.valid;
    end
    e_top <= fetch.last ? fetch.here : blend(fetch.here, fetch.right, fetch.fx);
    e_bot <= blend(fetch.below, fetch.diag, fetch.fx);
    e_fy  <= fetch.last ? '0 : fetch.fy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      sample_valid <= e_valid;
    end
    sample_value <= blend(e_top, e_bot, e_fy);
  end

endmodule

// File: tb/sv/wbgs_sample_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbgs_sample_checker
// Watches the request and result channels of the grid sampler. Keeps its own
// copy of the byte grid, predicts the blended byte of every accepted sample
// beat and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module wbgs_sample_checker #(
  parameter int GRID_WIDTH  = wbgs_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = wbgs_pkg::GRID_HEIGHT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic                                  req_type,
  input  logic [wbgs_pkg::INDEX_W-1:0]          write_index,
  input  logic [wbgs_pkg::VALUE_W-1:0]          write_value,
  input  logic signed [wbgs_pkg::COORD_X_W-1:0] coord_x,
  input  logic signed [wbgs_pkg::COORD_Y_W-1:0] coord_y,
  input  logic                                  sample_valid,
  input  logic [wbgs_pkg::VALUE_W-1:0]          sample_value,
  output int                                    failures,
  output int                                    pending
);
  import wbgs_pkg::*;

  localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
  localparam int X_SPAN = GRID_WIDTH << FRAC_W;
  localparam int Y_SPAN = GRID_HEIGHT << FRAC_W;

  byte_t grid_mem [CELLS];
  byte_t sample_q [$];

  function automatic byte_t mix(input byte_t a, input byte_t b, input frac_t f);
    int acc;
    acc = int'(a) * (256 - int'(f)) + int'(b) * int'(f);
    return byte_t'(acc >> FRAC_W);
  endfunction

  function automatic int wrap_fix(input int v, input int span);
    int r;
    r = v % span;
    if (r < 0) r += span;
    return r;
  endfunction

  function automatic byte_t predict_sample(input int cx, input int cy);
    int    x;
    int    y;
    int    xi;
    int    yi;
    int    base;
    frac_t fx;
    frac_t fy;
    byte_t top_mix;
    byte_t low_mix;
    x    = wrap_fix(cx, X_SPAN);
    y    = wrap_fix(cy, Y_SPAN);
    xi   = x >> FRAC_W;
    yi   = y >> FRAC_W;
    fx   = frac_t'(x);
    fy   = frac_t'(y);
    base = xi + yi * GRID_WIDTH;
    if (xi == GRID_WIDTH - 1 || yi == GRID_HEIGHT - 1) return grid_mem[base];
    top_mix = mix(grid_mem[base], grid_mem[base + 1], fx);
    low_mix = mix(grid_mem[base + GRID_WIDTH], grid_mem[base + GRID_WIDTH + 1], fx);
    return mix(top_mix, low_mix, fy);
  endfunction

  always @(posedge clk) begin : watch
    byte_t want;
    if (rst) begin
      foreach (grid_mem[i]) grid_mem[i] = '0;
      sample_q.delete();
    end else begin
      if (sample_valid !== 1'b0) begin
        if (sample_q.size() == 0) begin
          $display("%0t: result with no sample pending, expected none, got %0d",
                   $time, sample_value);
          failures++;
        end else begin
          want = sample_q.pop_front();
          if (sample_value !== want) begin
            $display("%0t: sample_value mismatch, expected %0d, got %0d",
                     $time, want, sample_value);
            failures++;
          end
        end
      end
      if (start && !busy) begin
        if (req_t'(req_type) == REQ_WRITE) begin
          if (int'(write_index) < CELLS) grid_mem[int'(write_index)] = write_value;
        end else begin
          sample_q.push_back(predict_sample(int'(coord_x), int'(coord_y)));
        end
      end
    end
    pending = sample_q.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives write and sample beats into the grid sampler: a directed pass over
// grid corners, wrap edges and blend weights, then random neighborhood loads
// followed by samples inside them, with random idle gaps. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import wbgs_pkg::*;

  localparam int W        = GRID_WIDTH_DEF;
  localparam int H        = GRID_HEIGHT_DEF;
  localparam int CELLS    = W * H;
  localparam int X_SPAN   = W << FRAC_W;
  localparam int Y_SPAN   = H << FRAC_W;
  localparam int ITEMS    = 700;
  localparam int DRAIN    = 16;
  localparam int LIMIT    = 300000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          req_type = REQ_WRITE;
  logic [INDEX_W-1:0]            write_index = '0;
  logic [VALUE_W-1:0]            write_value = '0;
  logic signed [COORD_X_W-1:0]   coord_x = '0;
  logic signed [COORD_Y_W-1:0]   coord_y = '0;
  logic                          sample_valid;
  logic [VALUE_W-1:0]            sample_value;
  int                            failures;
  int                            pending;
  int unsigned                   cycle_count = 0;
  int                            beats_sent = 0;
  bit                            quiet_stretch = 1'b0;

  wrapped_bilinear_grid_sampler #(.GRID_WIDTH(W), .GRID_HEIGHT(H)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .write_index(write_index), .write_value(write_value), .coord_x(coord_x),
    .coord_y(coord_y), .sample_valid(sample_valid), .sample_value(sample_value)
  );

  wbgs_sample_checker #(.GRID_WIDTH(W), .GRID_HEIGHT(H)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .write_index(write_index), .write_value(write_value), .coord_x(coord_x),
    .coord_y(coord_y), .sample_valid(sample_valid), .sample_value(sample_value),
    .failures(failures), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("** wrapped_bilinear_grid_sampler: FAILED **");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic byte_t pick_value();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return byte_t'($urandom);
  endfunction

  function automatic frac_t pick_frac();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return frac_t'($urandom);
  endfunction

  function automatic int fold(input int v, input int span, input int lo, input int hi);
    int k;
    int w;
    k = int'($urandom_range(0, 3)) - 2;
    w = v + k * span;
    if (w < lo || w > hi) return v;
    return w;
  endfunction

  task automatic issue(input req_t kind, input logic [INDEX_W-1:0] idx,
                       input byte_t val, input int cx, input int cy);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= kind;
    write_index <= idx;
    write_value <= val;
    coord_x     <= cx[COORD_X_W-1:0];
    coord_y     <= cy[COORD_Y_W-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    if (beats_sent % 64 == 0) quiet_stretch = ($urandom_range(0, 2) == 0);
  endtask

  task automatic put_cell(input int idx, input byte_t val);
    issue(REQ_WRITE, idx[INDEX_W-1:0], val, int'($urandom), int'($urandom));
  endtask

  task automatic take_sample(input int cx, input int cy);
    issue(REQ_SAMPLE, INDEX_W'($urandom), byte_t'($urandom), cx, cy);
  endtask

  task automatic run_directed();
    take_sample(0, 0);
    put_cell(0, 8'd255);
    put_cell(1, 8'd0);
    put_cell(W, 8'd0);
    put_cell(W + 1, 8'd255);
    take_sample(0, 0);
    take_sample(255, 0);
    take_sample(0, 255);
    take_sample(128, 128);
    take_sample(255, 255);
    put_cell(W - 1, 8'd200);
    take_sample(-1, 0);
    put_cell(CELLS - 1, 8'd255);
    take_sample(-1, -1);
    put_cell(CELLS, 8'd77);
    put_cell(65535, 8'd1);
    put_cell((H - 1) * W, 8'd9);
    take_sample(200, ((H - 1) << FRAC_W) + 255);
    take_sample(-(1 << (COORD_X_W - 1)), -(1 << (COORD_Y_W - 1)));
    take_sample((1 << (COORD_X_W - 1)) - 1, (1 << (COORD_Y_W - 1)) - 1);
    take_sample(-X_SPAN, -Y_SPAN);
    take_sample(2 * X_SPAN - 1, 2 * Y_SPAN - 1);
    take_sample(X_SPAN, Y_SPAN + 128);
  endtask

  task automatic run_random();
    int counted;
    int r;
    int xi;
    int yi;
    int n;
    int idx;
    int x_lo;
    int x_hi;
    int y_lo;
    int y_hi;
    counted = 0;
    x_lo = -(1 << (COORD_X_W - 1));
    x_hi = (1 << (COORD_X_W - 1)) - 1;
    y_lo = -(1 << (COORD_Y_W - 1));
    y_hi = (1 << (COORD_Y_W - 1)) - 1;
    while (counted < ITEMS) begin
      r = $urandom_range(0, 9);
      if (r <= 5) begin
        xi = ($urandom_range(0, 7) == 0) ? W - 1 : $urandom_range(0, W - 1);
        yi = ($urandom_range(0, 7) == 0) ? H - 1 : $urandom_range(0, H - 1);
        idx = xi + yi * W;
        if ($urandom_range(0, 3) != 0) begin put_cell(idx, pick_value()); counted++; end
        if ($urandom_range(0, 3) != 0) begin
          put_cell((idx + 1) % CELLS, pick_value());
          counted++;
        end
        if ($urandom_range(0, 3) != 0) begin
          put_cell((idx + W) % CELLS, pick_value());
          counted++;
        end
        if ($urandom_range(0, 3) != 0) begin
          put_cell((idx + W + 1) % CELLS, pick_value());
          counted++;
        end
        n = $urandom_range(1, 3);
        repeat (n) begin
          take_sample(fold((xi << FRAC_W) + int'(pick_frac()), X_SPAN, x_lo, x_hi),
                      fold((yi << FRAC_W) + int'(pick_frac()), Y_SPAN, y_lo, y_hi));
          counted++;
        end
      end else if (r == 6) begin
        idx = $urandom_range(0, 65535);
        put_cell(idx, pick_value());
        if (idx < CELLS) counted++;
      end else if (r == 7) begin
        take_sample(int'($urandom), int'($urandom));
        counted++;
      end else if (r == 8) begin
        put_cell($urandom_range(CELLS, 65535), pick_value());
      end else begin
        take_sample(int'($urandom_range(0, 3 * X_SPAN - 1)) - X_SPAN,
                    int'($urandom_range(0, 3 * Y_SPAN - 1)) - Y_SPAN);
        counted++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("** wrapped_bilinear_grid_sampler: PASSED **");
    end else begin
      $display("** wrapped_bilinear_grid_sampler: FAILED **");
    end
    $finish;
  end

endmodule
